### rtl/core/assert_macros.svh
// Assertion macros shared by the capped distance map stamp RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/cdms_pkg.sv
// Package: constants, stencil table, state and command types of the distance map stamp.
package cdms_pkg;

    localparam int GRID_SIDE = 256;
    localparam int DMAX      = 8;
    localparam int SPAN      = 2 * DMAX + 1;
    localparam int STEN_N    = SPAN * SPAN;
    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int CELL_W    = 2 * ROW_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CENTRE    = GRID_SIDE / 2;
    localparam int COORD_W   = 8;
    localparam int DIST_W    = 4;
    localparam int IDX_W     = 16;
    localparam int CNT_W     = 17;
    localparam int MEM_W     = IDX_W + 1;
    localparam int SPAN_W    = $clog2(SPAN);
    localparam int STEN_W    = $clog2(STEN_N);
    localparam int SUM_W     = ((ROW_W > SPAN_W) ? ROW_W : SPAN_W) + 1;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef logic [STEN_N-1:0][DIST_W-1:0] t_stencil;

    function automatic t_stencil build_stencil();
        t_stencil s;
        int dx;
        int dy;
        int sq;
        int r;
        s = '0;
        for (int rr = 0; rr < SPAN; rr++) begin
            for (int cc = 0; cc < SPAN; cc++) begin
                dx = (cc >= DMAX) ? cc - DMAX : DMAX - cc;
                dy = (rr >= DMAX) ? rr - DMAX : DMAX - rr;
                sq = dx * dx + dy * dy;
                r  = 0;
                while (r < DMAX && (r + 1) * (r + 1) <= sq) begin
                    r++;
                end
                s[rr * SPAN + cc] = DIST_W'(r);
            end
        end
        return s;
    endfunction

    localparam t_stencil STENCIL = build_stencil();

    typedef enum logic [2:0] {
        S_CLEAR,
        S_SEED,
        S_IDLE,
        S_MARK,
        S_SWEEP,
        S_DRAIN,
        S_LOOK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic load_seed;
        logic clr_wr;
        logic mark;
        logic sweep_rd;
        logic look;
        logic resp;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/cdms_if.sv
// Channel interfaces: input word and result word with valid/ready handshake.
interface cdms_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [cdms_pkg::COORD_W-1:0] cell_col;
    logic [cdms_pkg::COORD_W-1:0] cell_row;

    modport source (output valid, kind, cell_col, cell_row, input ready);
    modport sink   (input valid, kind, cell_col, cell_row, output ready);
endinterface

interface cdms_out_if;
    logic                        valid;
    logic                        ready;
    logic [cdms_pkg::DIST_W-1:0] distance;
    logic                        occupied;
    logic [cdms_pkg::IDX_W-1:0]  particle_index;
    logic [cdms_pkg::CNT_W-1:0]  cluster_count;

    modport source (output valid, distance, occupied, particle_index, cluster_count,
                    input ready);
    modport sink   (input valid, distance, occupied, particle_index, cluster_count,
                    output ready);
endinterface

### rtl/core/cdms_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module cdms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cdms_ctrl.sv
// Controller: clearing pass, seed stamp, add and read sequencing.
`include "assert_macros.svh"
module cdms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_kind,
    input  cdms_pkg::t_stat i_stat,
    output cdms_pkg::t_cmd  o_cmd
);

    cdms_pkg::t_state r_state;
    cdms_pkg::t_state n_state;
    logic             r_seed;
    logic             n_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdms_pkg::S_CLEAR;
            r_seed  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
        end
    end

    always_comb begin
        n_state = r_state;
        n_seed  = r_seed;
        case (r_state)
            cdms_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = cdms_pkg::S_SEED;
                end
            end
            cdms_pkg::S_SEED: begin
                n_seed  = 1'b1;
                n_state = cdms_pkg::S_MARK;
            end
            cdms_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_kind == cdms_pkg::KIND_ADD) ? cdms_pkg::S_MARK
                                                                : cdms_pkg::S_LOOK;
                end
            end
            cdms_pkg::S_MARK: begin
                n_state = cdms_pkg::S_SWEEP;
            end
            cdms_pkg::S_SWEEP: begin
                if (i_stat.sweep_last) begin
                    n_state = cdms_pkg::S_DRAIN;
                end
            end
            cdms_pkg::S_DRAIN: begin
                n_seed  = 1'b0;
                n_state = r_seed ? cdms_pkg::S_IDLE : cdms_pkg::S_LOOK;
            end
            cdms_pkg::S_LOOK: begin
                n_state = cdms_pkg::S_RESP;
            end
            cdms_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = cdms_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdms_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            cdms_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
            end
            cdms_pkg::S_SEED: begin
                o_cmd.load_seed = 1'b1;
            end
            cdms_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.load_in  = i_in_valid;
            end
            cdms_pkg::S_MARK: begin
                o_cmd.mark = 1'b1;
            end
            cdms_pkg::S_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
            end
            cdms_pkg::S_LOOK: begin
                o_cmd.look = 1'b1;
            end
            cdms_pkg::S_RESP: begin
                o_cmd.resp = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_cmd.load_in, r_state == cdms_pkg::S_MARK || r_state == cdms_pkg::S_LOOK)
    `ASSERT_NEXT(a_sweep_ends, i_clk, i_rst_n, r_state == cdms_pkg::S_SWEEP && i_stat.sweep_last, r_state == cdms_pkg::S_DRAIN)
    `ASSERT_NEXT(a_seed_silent, i_clk, i_rst_n, r_state == cdms_pkg::S_DRAIN && r_seed, r_state == cdms_pkg::S_IDLE)
    `ASSERT_NEXT(a_resp_done, i_clk, i_rst_n, o_cmd.resp, r_state == cdms_pkg::S_IDLE && !r_seed)

endmodule

### rtl/core/cdms_dp.sv
// Datapath: distance and member memories, stencil sweep, particle count, result register.
module cdms_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [cdms_pkg::COORD_W-1:0] i_cell_col,
    input  logic [cdms_pkg::COORD_W-1:0] i_cell_row,
    input  cdms_pkg::t_cmd               i_cmd,
    output cdms_pkg::t_stat              o_stat,
    cdms_out_if.source                   o_out
);

    logic [cdms_pkg::ROW_W-1:0]  r_col;
    logic [cdms_pkg::ROW_W-1:0]  r_row;
    logic [cdms_pkg::SPAN_W-1:0] r_sr;
    logic [cdms_pkg::SPAN_W-1:0] r_sc;
    logic [cdms_pkg::STEN_W-1:0] r_sk;
    logic [cdms_pkg::CELL_W-1:0] r_clr;
    logic [cdms_pkg::CNT_W-1:0]  r_total;
    logic                        r_wr_pend;
    logic [cdms_pkg::CELL_W-1:0] r_wr_addr;
    logic [cdms_pkg::DIST_W-1:0] r_wr_sten;
    logic                        r_out_valid;
    logic [cdms_pkg::DIST_W-1:0] r_out_dist;
    logic                        r_out_occ;
    logic [cdms_pkg::IDX_W-1:0]  r_out_idx;
    logic [cdms_pkg::CNT_W-1:0]  r_out_cnt;

    logic [cdms_pkg::SUM_W-1:0]  tgt_row_sum;
    logic [cdms_pkg::SUM_W-1:0]  tgt_col_sum;
    logic [cdms_pkg::SUM_W-1:0]  tgt_row;
    logic [cdms_pkg::SUM_W-1:0]  tgt_col;
    logic                        tgt_in_grid;
    logic [cdms_pkg::CELL_W-1:0] tgt_addr;
    logic [cdms_pkg::CELL_W-1:0] cell_addr;
    logic                        below_cap;
    logic [cdms_pkg::IDX_W-1:0]  new_idx;

    logic                        dist_we;
    logic [cdms_pkg::CELL_W-1:0] dist_waddr;
    logic [cdms_pkg::DIST_W-1:0] dist_wdata;
    logic                        dist_re;
    logic [cdms_pkg::CELL_W-1:0] dist_raddr;
    logic [cdms_pkg::DIST_W-1:0] dist_rdata;
    logic                        mem_we;
    logic [cdms_pkg::CELL_W-1:0] mem_waddr;
    logic [cdms_pkg::MEM_W-1:0]  mem_wdata;
    logic [cdms_pkg::MEM_W-1:0]  mem_rdata;

    assign cell_addr   = {r_row, r_col};
    assign tgt_row_sum = cdms_pkg::SUM_W'(r_row) + cdms_pkg::SUM_W'(r_sr);
    assign tgt_col_sum = cdms_pkg::SUM_W'(r_col) + cdms_pkg::SUM_W'(r_sc);
    assign tgt_row     = tgt_row_sum - cdms_pkg::SUM_W'(cdms_pkg::DMAX);
    assign tgt_col     = tgt_col_sum - cdms_pkg::SUM_W'(cdms_pkg::DMAX);
    assign tgt_in_grid =
        (tgt_row_sum >= cdms_pkg::SUM_W'(cdms_pkg::DMAX)) &&
        (tgt_row_sum <  cdms_pkg::SUM_W'(cdms_pkg::GRID_SIDE + cdms_pkg::DMAX)) &&
        (tgt_col_sum >= cdms_pkg::SUM_W'(cdms_pkg::DMAX)) &&
        (tgt_col_sum <  cdms_pkg::SUM_W'(cdms_pkg::GRID_SIDE + cdms_pkg::DMAX));
    assign tgt_addr    = {tgt_row[cdms_pkg::ROW_W-1:0], tgt_col[cdms_pkg::ROW_W-1:0]};

    assign below_cap = r_total < cdms_pkg::CNT_W'(cdms_pkg::CELLS);
    assign new_idx   = below_cap ? r_total[cdms_pkg::IDX_W-1:0]
                                 : cdms_pkg::IDX_W'(cdms_pkg::CELLS - 1);

    // Cell coordinates and sweep counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= cdms_pkg::ROW_W'(i_cell_col);
            r_row <= cdms_pkg::ROW_W'(i_cell_row);
        end else if (i_cmd.load_seed) begin
            r_col <= cdms_pkg::ROW_W'(cdms_pkg::CENTRE);
            r_row <= cdms_pkg::ROW_W'(cdms_pkg::CENTRE);
        end
        if (i_cmd.load_in || i_cmd.load_seed) begin
            r_sr <= '0;
            r_sc <= '0;
            r_sk <= '0;
        end else if (i_cmd.sweep_rd) begin
            r_sk <= r_sk + 1'b1;
            if (r_sc == cdms_pkg::SPAN_W'(cdms_pkg::SPAN - 1)) begin
                r_sc <= '0;
                r_sr <= r_sr + 1'b1;
            end else begin
                r_sc <= r_sc + 1'b1;
            end
        end
        r_wr_addr <= tgt_addr;
        r_wr_sten <= cdms_pkg::STENCIL[r_sk];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_total     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.mark && below_cap) begin
                r_total <= r_total + 1'b1;
            end
            r_wr_pend <= i_cmd.sweep_rd && tgt_in_grid;
            if (i_cmd.resp) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_dist <= dist_rdata;
            r_out_occ  <= mem_rdata[cdms_pkg::IDX_W];
            r_out_idx  <= mem_rdata[cdms_pkg::IDX_W] ? mem_rdata[cdms_pkg::IDX_W-1:0] : '0;
            r_out_cnt  <= r_total;
        end
    end

    assign dist_we    = i_cmd.clr_wr || (r_wr_pend && (r_wr_sten < dist_rdata));
    assign dist_waddr = i_cmd.clr_wr ? r_clr : r_wr_addr;
    assign dist_wdata = i_cmd.clr_wr ? cdms_pkg::DIST_W'(cdms_pkg::DMAX) : r_wr_sten;
    assign dist_re    = i_cmd.sweep_rd || i_cmd.look;
    assign dist_raddr = i_cmd.look ? cell_addr : tgt_addr;

    assign mem_we    = i_cmd.clr_wr || i_cmd.mark;
    assign mem_waddr = i_cmd.clr_wr ? r_clr : cell_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : {1'b1, new_idx};

    cdms_ram #(
        .WIDTH (cdms_pkg::DIST_W),
        .DEPTH (cdms_pkg::CELLS)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_re    (dist_re),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    cdms_ram #(
        .WIDTH (cdms_pkg::MEM_W),
        .DEPTH (cdms_pkg::CELLS)
    ) u_member_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd.look),
        .i_raddr (cell_addr),
        .o_rdata (mem_rdata)
    );

    assign o_stat.clr_last   = (r_clr == {cdms_pkg::CELL_W{1'b1}});
    assign o_stat.sweep_last = (r_sk == cdms_pkg::STEN_W'(cdms_pkg::STEN_N - 1));
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid          = r_out_valid;
    assign o_out.distance       = r_out_dist;
    assign o_out.occupied       = r_out_occ;
    assign o_out.particle_index = r_out_idx;
    assign o_out.cluster_count  = r_out_cnt;

endmodule

### rtl/core/capped_distance_map_stamp.sv
// Top level: capped distance map with particle stamping, controller plus datapath.
// Add word: marks the cell, then the stencil sweep does one distance read-modify-write
//   per cycle through the distance memory (289 cells), then the cell is read as for a read word.
// Read word: looks up the cell, then registers the result once the output is free. One word in flight.
// Reset: a clearing pass over all 65536 cells, then a seed stamp at the centre;
//   no input word is taken until both are done.
module capped_distance_map_stamp (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdms_in_if.sink    i_in,
    cdms_out_if.source o_out
);

    cdms_pkg::t_cmd  cmd;
    cdms_pkg::t_stat stat;

    assign i_in.ready = cmd.in_ready;

    cdms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cdms_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell_col (i_in.cell_col),
        .i_cell_row (i_in.cell_row),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out      (o_out)
    );

endmodule
